@@ hdl/gtg_pkg.sv @@
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Payload structs, register indexes, pipeline widths and the CORDIC angle table.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Input pose, one transfer per accepted start
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
  } in_t;

  // Velocity command, one transfer per strobe
  typedef struct packed {
    logic        [14:0] linear_cmd;
    logic signed [15:0] angular_cmd;
  } out_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR = 3'd4;

  // Register reset values
  localparam logic signed [15:0] TARGET_X_RST    = 16'sd5120;
  localparam logic signed [15:0] TARGET_Y_RST    = 16'sd5120;
  localparam logic        [14:0] GAIN_RST        = 15'd1024;
  localparam logic        [14:0] MAX_LINEAR_RST  = 15'd1024;
  localparam logic        [14:0] MAX_ANGULAR_RST = 15'd1024;

  // Offsets are 17 bits, the squared sum 34 bits, the root 17 bits
  localparam int DIFF_W      = 17;
  localparam int RAD_W       = 34;
  localparam int ROOT_W      = 17;
  localparam int SQRT_STAGES = 17;

  // CORDIC datapath: offsets scaled by 2^14, angle in Q2.30
  localparam int CORDIC_W    = 34;
  localparam int PRESCALE_SH = 14;
  localparam int ANG_FRAC    = 30;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [16] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768
  };

  // Vector handed to the CORDIC pipe
  typedef struct packed {
    logic                       valid;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic signed [15:0]         head;
  } cordic_vec_t;

endpackage

@@ hdl/gtg_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// gtg_sqrt_pipe: pipelined integer square root
// One result bit per stage; floor root of a 34-bit radicand in 17 stages.
// ----------------------------------------------------------------------------
module gtg_sqrt_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [gtg_pkg::RAD_W-1:0]     in_radicand,
  output logic                          out_valid,
  output logic [gtg_pkg::ROOT_W-1:0]    out_root
);

  localparam int N   = gtg_pkg::SQRT_STAGES;
  localparam int RW  = gtg_pkg::RAD_W;
  localparam int ACW = gtg_pkg::RAD_W + 1;

  logic            valid_r [N];
  logic [RW-1:0]   rem_r   [N];
  logic [ACW-1:0]  res_r   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [ACW-1:0] BIT = ACW'(1) << (2 * (N - 1 - i));

    logic           valid_in;
    logic [RW-1:0]  rem_in;
    logic [ACW-1:0] res_in;
    logic [ACW-1:0] trial;
    logic           take;
    logic [RW-1:0]  rem_nxt;
    logic [ACW-1:0] res_nxt;

    if (i == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_radicand;
      assign res_in   = '0;
    end else begin : g_next
      assign valid_in = valid_r[i-1];
      assign rem_in   = rem_r[i-1];
      assign res_in   = res_r[i-1];
    end

    always_comb begin
      trial   = res_in + BIT;
      take    = {1'b0, rem_in} >= trial;
      rem_nxt = take ? (rem_in - trial[RW-1:0]) : rem_in;
      res_nxt = take ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      res_r[i] <= res_nxt;
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = res_r[N-1][gtg_pkg::ROOT_W-1:0];

endmodule

@@ hdl/gtg_cordic_pipe.sv @@
// ----------------------------------------------------------------------------
// gtg_cordic_pipe: pipelined vectoring CORDIC for the bearing
// One micro-rotation per stage, padded to the depth of the square-root pipe.
// ----------------------------------------------------------------------------
module gtg_cordic_pipe #(
  parameter int CORDIC_STEPS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gtg_pkg::cordic_vec_t                 in_vec,
  output logic                                 out_valid,
  output logic signed [gtg_pkg::CORDIC_W-1:0]  out_angle,
  output logic signed [15:0]                   out_head
);

  localparam int N = gtg_pkg::SQRT_STAGES;

  gtg_pkg::cordic_vec_t vec_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    gtg_pkg::cordic_vec_t vec_in;
    gtg_pkg::cordic_vec_t vec_nxt;

    if (i == 0) begin : g_first
      assign vec_in = in_vec;
    end else begin : g_next
      assign vec_in = vec_r[i-1];
    end

    if (i < CORDIC_STEPS) begin : g_rotate
      always_comb begin
        vec_nxt = vec_in;
        // rotate toward the x axis, accumulate the angle
        if (vec_in.y > 0) begin
          vec_nxt.x = vec_in.x + (vec_in.y >>> i);
          vec_nxt.y = vec_in.y - (vec_in.x >>> i);
          vec_nxt.z = vec_in.z + gtg_pkg::ATAN_Q30[i];
        end else begin
          vec_nxt.x = vec_in.x - (vec_in.y >>> i);
          vec_nxt.y = vec_in.y + (vec_in.x >>> i);
          vec_nxt.z = vec_in.z - gtg_pkg::ATAN_Q30[i];
        end
      end
    end else begin : g_pad
      assign vec_nxt = vec_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vec_r[i].valid <= 1'b0;
      end else begin
        vec_r[i].valid <= vec_nxt.valid;
      end
      vec_r[i].x    <= vec_nxt.x;
      vec_r[i].y    <= vec_nxt.y;
      vec_r[i].z    <= vec_nxt.z;
      vec_r[i].head <= vec_nxt.head;
    end
  end

  assign out_valid = vec_r[N-1].valid;
  assign out_angle = vec_r[N-1].z;
  assign out_head  = vec_r[N-1].head;

endmodule

@@ hdl/gtg_cmd_stage.sv @@
// ----------------------------------------------------------------------------
// gtg_cmd_stage: command selection and saturation
// Rounds the bearing, forms the heading error and the scaled distance, then
// picks stop, turn or drive and clamps into the output register.
// ----------------------------------------------------------------------------
module gtg_cmd_stage #(
  parameter int FRAC_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [gtg_pkg::ROOT_W-1:0]           in_dist,
  input  logic signed [gtg_pkg::CORDIC_W-1:0]  in_angle,
  input  logic signed [15:0]                   in_head,
  input  logic [14:0]                          gain,
  input  logic [14:0]                          max_linear,
  input  logic [14:0]                          max_angular,
  output logic                                 out_valid,
  output gtg_pkg::out_t                        out_payload
);

  localparam int CW      = gtg_pkg::CORDIC_W;
  localparam int SH      = gtg_pkg::ANG_FRAC - FRAC_BITS;
  localparam int DIST_TH = ((1 << FRAC_BITS) + 5) / 10;
  localparam int ANG_TH  = ((1 << (FRAC_BITS + 1)) + 5) / 10;
  localparam int ERR_W   = 20;
  localparam int PROD_W  = 32;
  localparam logic signed [CW-1:0] RND = CW'(1) << (SH - 1);

  // stage A
  logic                    valid_a_r;
  logic                    far_r, far_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [CW-1:0]    bear;
  logic signed [CW-1:0]    err_full;

  always_comb begin
    far_nxt  = in_dist > gtg_pkg::ROOT_W'(DIST_TH);
    bear     = (in_angle + RND) >>> SH;
    err_full = bear - CW'(in_head);
    err_nxt  = err_full[ERR_W-1:0];
    prod_nxt = PROD_W'(gain) * PROD_W'(in_dist);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    far_r  <= far_nxt;
    err_r  <= err_nxt;
    prod_r <= prod_nxt;
  end

  // stage B
  logic                    out_valid_r;
  gtg_pkg::out_t           out_payload_r, out_payload_nxt;
  logic [ERR_W-1:0]        mag;
  logic                    turn;
  logic [PROD_W-1:0]       lin_full;
  logic signed [ERR_W-1:0] lim;
  logic signed [ERR_W-1:0] ang;

  always_comb begin
    mag      = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    turn     = mag > ERR_W'(ANG_TH);
    lin_full = prod_r >> FRAC_BITS;
    lim      = $signed(ERR_W'(max_angular));
    if (err_r > lim) begin
      ang = lim;
    end else if (err_r < -lim) begin
      ang = -lim;
    end else begin
      ang = err_r;
    end

    out_payload_nxt.linear_cmd  = '0;
    out_payload_nxt.angular_cmd = '0;
    if (far_r) begin
      if (turn) begin
        out_payload_nxt.angular_cmd = ang[15:0];
      end else if (lin_full > PROD_W'(max_linear)) begin
        out_payload_nxt.linear_cmd = max_linear;
      end else begin
        out_payload_nxt.linear_cmd = lin_full[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    out_payload_r <= out_payload_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

@@ hdl/go_to_goal_p_controller_unit.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_unit: proportional go-to-goal velocity controller
// Turns each robot pose into one linear/angular command toward a stored goal.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                   | Transfer
//  --------+-----------------------------------------+------------------------------
//  pose    | start, busy, in_payload                 | edge with start high, busy low
//  command | out_valid, out_payload                  | every edge ending out_valid
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | edge with valid and ready high
//
//  A pose can enter every cycle; busy is high only while rst_n is low.
//  Each command leaves through the offset, square and sum stages, the 17-stage
//  square-root pipe and the command stage; the CORDIC pipe runs beside the root pipe at equal depth.
//  Synchronous reset empties the pipeline and restores the goal, gain and limits.
//  The command side has no back-pressure, so the pipeline never stalls.
//  Write configuration only while no pose is in flight.
//
module go_to_goal_p_controller_unit #(
  parameter int FRAC_BITS    = 10,
  parameter int CORDIC_STEPS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pose channel
  input  logic                               start,
  output logic                               busy,
  input  gtg_pkg::in_t                       in_payload,
  // command channel
  output logic                               out_valid,
  output gtg_pkg::out_t                      out_payload,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);

  localparam int DW = gtg_pkg::DIFF_W;
  localparam int CW = gtg_pkg::CORDIC_W;
  localparam int LATENCY = 3 + gtg_pkg::SQRT_STAGES + 2;

  // Hold off transfers while reset is applied
  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  logic in_fire;
  assign in_fire = start && !busy;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] target_x_r;
  logic signed [15:0] target_y_r;
  logic [14:0]        gain_r;
  logic [14:0]        max_linear_r;
  logic [14:0]        max_angular_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r    <= gtg_pkg::TARGET_X_RST;
      target_y_r    <= gtg_pkg::TARGET_Y_RST;
      gain_r        <= gtg_pkg::GAIN_RST;
      max_linear_r  <= gtg_pkg::MAX_LINEAR_RST;
      max_angular_r <= gtg_pkg::MAX_ANGULAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to indexes beyond the register list
      case (cfg_index)
        gtg_pkg::REG_TARGET_X:    target_x_r    <= $signed(cfg_data);
        gtg_pkg::REG_TARGET_Y:    target_y_r    <= $signed(cfg_data);
        gtg_pkg::REG_GAIN:        gain_r        <= cfg_data[14:0];
        gtg_pkg::REG_MAX_LINEAR:  max_linear_r  <= cfg_data[14:0];
        gtg_pkg::REG_MAX_ANGULAR: max_angular_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: goal offset at 17 bits
  // --------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic signed [DW-1:0] s1_dx_r, s1_dx_nxt;
  logic signed [DW-1:0] s1_dy_r, s1_dy_nxt;
  logic signed [15:0]   s1_head_r;

  always_comb begin
    s1_dx_nxt = DW'(target_x_r) - DW'(in_payload.pos_x);
    s1_dy_nxt = DW'(target_y_r) - DW'(in_payload.pos_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r   <= s1_dx_nxt;
    s1_dy_r   <= s1_dy_nxt;
    s1_head_r <= in_payload.heading;
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares, CORDIC prescale and quadrant pre-rotation
  // --------------------------------------------------------------------------
  logic [31:0]              s2_dxx_r, s2_dyy_r;
  logic signed [2*DW-1:0]   dxx_full, dyy_full;
  gtg_pkg::cordic_vec_t     s2_vec_r, s2_vec_nxt;
  logic signed [CW-1:0]     x_pre, y_pre;

  always_comb begin
    dxx_full = s1_dx_r * s1_dx_r;
    dyy_full = s1_dy_r * s1_dy_r;
    x_pre    = CW'(s1_dx_r) <<< gtg_pkg::PRESCALE_SH;
    y_pre    = CW'(s1_dy_r) <<< gtg_pkg::PRESCALE_SH;

    s2_vec_nxt.valid = s1_valid_r;
    s2_vec_nxt.head  = s1_head_r;
    s2_vec_nxt.x     = x_pre;
    s2_vec_nxt.y     = y_pre;
    s2_vec_nxt.z     = '0;
    // fold the left half plane into the right by a quarter turn
    if (x_pre < 0) begin
      if (y_pre >= 0) begin
        s2_vec_nxt.x = y_pre;
        s2_vec_nxt.y = -x_pre;
        s2_vec_nxt.z = gtg_pkg::HALF_PI_Q30;
      end else begin
        s2_vec_nxt.x = -y_pre;
        s2_vec_nxt.y = x_pre;
        s2_vec_nxt.z = -gtg_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vec_r.valid <= 1'b0;
    end else begin
      s2_vec_r.valid <= s2_vec_nxt.valid;
    end
    s2_dxx_r      <= dxx_full[31:0];
    s2_dyy_r      <= dyy_full[31:0];
    s2_vec_r.x    <= s2_vec_nxt.x;
    s2_vec_r.y    <= s2_vec_nxt.y;
    s2_vec_r.z    <= s2_vec_nxt.z;
    s2_vec_r.head <= s2_vec_nxt.head;
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum of squares; advance the CORDIC vector alongside
  // --------------------------------------------------------------------------
  logic [gtg_pkg::RAD_W-1:0]    s3_sum_r, s3_sum_nxt;
  gtg_pkg::cordic_vec_t         s3_vec_r;

  assign s3_sum_nxt = gtg_pkg::RAD_W'(s2_dxx_r) + gtg_pkg::RAD_W'(s2_dyy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vec_r.valid <= 1'b0;
    end else begin
      s3_vec_r.valid <= s2_vec_r.valid;
    end
    s3_sum_r      <= s3_sum_nxt;
    s3_vec_r.x    <= s2_vec_r.x;
    s3_vec_r.y    <= s2_vec_r.y;
    s3_vec_r.z    <= s2_vec_r.z;
    s3_vec_r.head <= s2_vec_r.head;
  end

  // --------------------------------------------------------------------------
  // Distance and bearing pipes, equal depth
  // --------------------------------------------------------------------------
  logic                          sq_valid;
  logic [gtg_pkg::ROOT_W-1:0]    sq_root;
  logic                          co_valid;
  logic signed [CW-1:0]          co_angle;
  logic signed [15:0]            co_head;

  gtg_sqrt_pipe u_sqrt (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s3_vec_r.valid),
    .in_radicand (s3_sum_r),
    .out_valid   (sq_valid),
    .out_root    (sq_root)
  );

  gtg_cordic_pipe #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vec    (s3_vec_r),
    .out_valid (co_valid),
    .out_angle (co_angle),
    .out_head  (co_head)
  );

  // --------------------------------------------------------------------------
  // Command selection and output register
  // --------------------------------------------------------------------------
  gtg_cmd_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cmd (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sq_valid),
    .in_dist     (sq_root),
    .in_angle    (co_angle),
    .in_head     (co_head),
    .gain        (gain_r),
    .max_linear  (max_linear_r),
    .max_angular (max_angular_r),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [15:0] ang_mag;
  assign ang_mag = out_payload.angular_cmd[15] ? 16'(-out_payload.angular_cmd)
                                               : 16'(out_payload.angular_cmd);

  a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid == co_valid)
    else $error("distance and bearing pipes out of step");

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("accepted pose produced no command");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("command without a matching pose");

  a_one_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.linear_cmd == '0 || out_payload.angular_cmd == '0))
    else $error("drive and turn commanded together");

  a_ang_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ang_mag <= {1'b0, max_angular_r}))
    else $error("angular command beyond its limit");

endmodule

@@ tb/sv/go_to_goal_p_controller_unit_tb.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_unit_tb: self-checking bench of the go-to-goal unit
// Drives robot poses and goal, gain and limit settings into the unit and checks every
// velocity command against a fixed-point model of the controller, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module go_to_goal_p_controller_unit_tb;

  // Model constants (Q5.10 values, Q2.30 bearing)
  localparam int     FRAC_W       = 10;
  localparam int     BEAR_FRAC_W  = 30;
  localparam int     ROT_STEPS    = 12;
  localparam longint NEAR_LIMIT   = ((64'sd1 << FRAC_W) + 5) / 10;
  localparam longint AIM_LIMIT    = ((64'sd1 << (FRAC_W + 1)) + 5) / 10;
  localparam longint ROT_PRESCALE = 64'sd16384;
  localparam int     PIPE_DEPTH   = 22;
  localparam int     SHOW_LIMIT   = 10;
  localparam int     IDX_W        = gtg_pkg::CFG_IDX_W;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  gtg_pkg::in_t         in_payload = '0;
  logic                 out_valid;
  gtg_pkg::out_t        out_payload;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index  = gtg_pkg::REG_TARGET_X;
  logic [15:0]          cfg_data   = '0;

  // Model copy of the registers
  logic signed [15:0] goal_x  = gtg_pkg::TARGET_X_RST;
  logic signed [15:0] goal_y  = gtg_pkg::TARGET_Y_RST;
  logic        [14:0] k_gain  = gtg_pkg::GAIN_RST;
  logic        [14:0] lin_max = gtg_pkg::MAX_LINEAR_RST;
  logic        [14:0] ang_max = gtg_pkg::MAX_ANGULAR_RST;

  // Commands predicted for accepted poses, oldest first
  gtg_pkg::out_t pending_cmds[$];
  int            fail_count = 0;

  go_to_goal_p_controller_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Floor square root, one result bit per pass
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned probe;
    rest  = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rest) probe >>= 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Bearing atan2(dy, dx) by vectoring rotations, rounded to Q5.10
  function automatic longint goal_bearing(longint dx, longint dy);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint t;
    x = dx * ROT_PRESCALE;
    y = dy * ROT_PRESCALE;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(gtg_pkg::HALF_PI_Q30);
      end else begin
        x = -y;
        y = t;
        z = -longint'(gtg_pkg::HALF_PI_Q30);
      end
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(gtg_pkg::ATAN_Q30[i]);
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(gtg_pkg::ATAN_Q30[i]);
      end
    end
    return (z + (64'sd1 << (BEAR_FRAC_W - FRAC_W - 1))) >>> (BEAR_FRAC_W - FRAC_W);
  endfunction

  // Velocity command for one pose under the current registers
  function automatic gtg_pkg::out_t steer_cmd(gtg_pkg::in_t pose);
    gtg_pkg::out_t   cmd;
    longint          dx;
    longint          dy;
    longint          err;
    longint          mag;
    longint          ang;
    longint unsigned reach;
    longint unsigned lin;
    dx    = longint'(goal_x) - longint'(pose.pos_x);
    dy    = longint'(goal_y) - longint'(pose.pos_y);
    reach = root_floor(longint'(dx * dx + dy * dy));
    lin   = 0;
    ang   = 0;
    // at goal both commands stay zero
    if (longint'(reach) > NEAR_LIMIT) begin
      err = goal_bearing(dx, dy) - longint'(pose.heading);
      mag = (err < 0) ? -err : err;
      if (mag > AIM_LIMIT) begin
        // turn in place, saturate symmetrically
        ang = err;
        if (ang > longint'(ang_max))  ang = longint'(ang_max);
        if (ang < -longint'(ang_max)) ang = -longint'(ang_max);
      end else begin
        // drive forward, clamp at the linear limit
        lin = (longint'(k_gain) * reach) >> FRAC_W;
        if (lin > longint'(lin_max)) lin = longint'(lin_max);
      end
    end
    cmd.linear_cmd  = lin[14:0];
    cmd.angular_cmd = ang[15:0];
    return cmd;
  endfunction

  // Pose at offset (dx, dy) short of the goal, heading error set to err
  function automatic gtg_pkg::in_t aimed_pose(longint dx, longint dy, longint err);
    gtg_pkg::in_t pose;
    pose.pos_x   = 16'(longint'(goal_x) - dx);
    pose.pos_y   = 16'(longint'(goal_y) - dy);
    pose.heading = 16'(goal_bearing(dx, dy) - err);
    return pose;
  endfunction

  // Random pose: raw noise, poses around the goal, and poses roughly on course
  function automatic gtg_pkg::in_t random_pose();
    gtg_pkg::in_t pose;
    int           kind;
    longint       dx;
    longint       dy;
    pose.pos_x   = 16'($urandom);
    pose.pos_y   = 16'($urandom);
    pose.heading = 16'($urandom);
    kind = $urandom_range(0, 9);
    if (kind == 3) begin
      pose.pos_x = goal_x + 16'($urandom_range(0, 300) - 150);
      pose.pos_y = goal_y + 16'($urandom_range(0, 300) - 150);
    end else if (kind >= 4) begin
      if ($urandom_range(0, 1) == 1) begin
        pose.pos_x = goal_x + 16'($urandom_range(0, 4000) - 2000);
        pose.pos_y = goal_y + 16'($urandom_range(0, 4000) - 2000);
      end
      dx = longint'(goal_x) - longint'(pose.pos_x);
      dy = longint'(goal_y) - longint'(pose.pos_y);
      pose.heading = 16'(goal_bearing(dx, dy) + longint'(int'($urandom_range(0, 600)) - 300));
    end
    return pose;
  endfunction

  // Transfer one pose; start stays high for the caller to keep or drop
  task automatic send_pose(input gtg_pkg::in_t pose);
    in_payload <= pose;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_cmds.push_back(steer_cmd(pose));
  endtask

  // In pct of a hundred transfers, drop start and idle the sender before the next pose
  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait until every predicted command has come out
  task automatic drain_cmds();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Transfer one register write; cfg_valid stays high for the caller to drop
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gtg_pkg::REG_TARGET_X:    goal_x  = value;
      gtg_pkg::REG_TARGET_Y:    goal_y  = value;
      gtg_pkg::REG_GAIN:        k_gain  = value[14:0];
      gtg_pkg::REG_MAX_LINEAR:  lin_max = value[14:0];
      gtg_pkg::REG_MAX_ANGULAR: ang_max = value[14:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] gx, input logic [15:0] gy,
                               input logic [15:0] gn, input logic [15:0] lm,
                               input logic [15:0] am);
    write_reg(gtg_pkg::REG_TARGET_X, gx);
    write_reg(gtg_pkg::REG_TARGET_Y, gy);
    write_reg(gtg_pkg::REG_GAIN, gn);
    write_reg(gtg_pkg::REG_MAX_LINEAR, lm);
    write_reg(gtg_pkg::REG_MAX_ANGULAR, am);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int pct);
    for (int n = 0; n < count; n++) begin
      send_pose(random_pose());
      sender_gap(pct);
    end
    start <= 1'b0;
    drain_cmds();
  endtask

  // Goal boundaries, both turn limits, every quadrant and field extremes
  task automatic test_directed_poses();
    send_pose(aimed_pose(0, 0, 0));
    send_pose(aimed_pose(102, 0, 0));
    send_pose(aimed_pose(72, 73, 0));
    send_pose(aimed_pose(103, 0, 0));
    send_pose(aimed_pose(103, 0, 205));
    send_pose(aimed_pose(2000, 1500, 205));
    send_pose(aimed_pose(2000, 1500, 206));
    send_pose(aimed_pose(2000, 1500, -205));
    send_pose(aimed_pose(2000, 1500, -206));
    send_pose(aimed_pose(-2000, 0, 0));
    send_pose(aimed_pose(-2000, -5, 0));
    send_pose(aimed_pose(0, 3000, 0));
    send_pose(aimed_pose(0, -3000, 0));
    send_pose(aimed_pose(30000, 20000, 0));
    send_pose(aimed_pose(3000, 0, 3000));
    send_pose(aimed_pose(3000, 0, -3000));
    send_pose('{pos_x: 16'sh8000, pos_y: 16'sh8000, heading: 16'sh7fff});
    send_pose('{pos_x: 16'sh7fff, pos_y: 16'sh7fff, heading: 16'sh8000});
    send_pose('{pos_x: 16'sh8000, pos_y: 16'sh7fff, heading: 16'sh0000});
    send_pose('{pos_x: 16'sh7fff, pos_y: 16'sh8000, heading: 16'shffff});
    start <= 1'b0;
    drain_cmds();
  endtask

  // Goals at the corners, zero and full gain and limits, masked and ignored writes
  task automatic test_register_extremes();
    apply_setting(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    run_random(40, 30);
    apply_setting(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    run_random(40, 30);
    apply_setting(16'h8000, 16'h7fff, 16'hffff, 16'h8000, 16'hffff);
    run_random(40, 30);
    // indexes beyond the last register must leave every register alone
    write_reg(IDX_W'(gtg_pkg::REG_MAX_ANGULAR + 1 + $urandom_range(0, 2)), 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    run_random(40, 0);
  endtask

  // Random settings per phase, sender idle share varied between phases
  task automatic test_random_traffic();
    int idle_pct[3];
    idle_pct = '{0, 45, 13};
    foreach (idle_pct[p]) begin
      apply_setting(16'($urandom), 16'($urandom),
                    ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 2048)) : 16'($urandom),
                    16'($urandom), 16'($urandom));
      run_random(340, idle_pct[p]);
    end
  endtask

  // Compare each command with the oldest prediction
  always @(posedge clk) begin
    if (out_valid) begin
      if (pending_cmds.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("[%0t] unexpected command lin=%0d ang=%0d", $realtime,
                   out_payload.linear_cmd, out_payload.angular_cmd);
      end else begin
        if (out_payload.linear_cmd  !== pending_cmds[0].linear_cmd ||
            out_payload.angular_cmd !== pending_cmds[0].angular_cmd) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("[%0t] command mismatch: lin exp %0d got %0d, ang exp %0d got %0d",
                     $realtime, pending_cmds[0].linear_cmd, out_payload.linear_cmd,
                     pending_cmds[0].angular_cmd, out_payload.angular_cmd);
        end
        void'(pending_cmds.pop_front());
      end
    end
  end

  initial begin
    // hold reset at the start, then release it once for the whole run
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_poses();
    test_register_extremes();
    test_random_traffic();

    // let the pipe empty out before the verdict
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (pending_cmds.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("go_to_goal_p_controller_unit_tb: clean");
    end else begin
      $display("go_to_goal_p_controller_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #5_000_000;
    $display("go_to_goal_p_controller_unit_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gtg_pkg.sv
hdl/gtg_sqrt_pipe.sv
hdl/gtg_cordic_pipe.sv
hdl/gtg_cmd_stage.sv
hdl/go_to_goal_p_controller_unit.sv
tb/sv/go_to_goal_p_controller_unit_tb.sv
